@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define R6R_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("r6r assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define R6R_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("r6r assertion failed");

`endif

@@ hw/rtl/r6r_pkg.sv @@
package r6r_pkg;

    // Array geometry and field widths.
    localparam int MAX_DISKS     = 16;
    localparam int DISK_W        = 4;
    localparam int DISK_COUNT_W  = 5;
    localparam int MASK_W        = 16;
    localparam int STRIPE_W      = 32;
    localparam int BYTE_W        = 8;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 16;

    // Input item packing in tdata, lowest field first.
    localparam int STRIPE_LSB    = 0;
    localparam int TARGET_LSB    = STRIPE_LSB + STRIPE_W;
    localparam int MEMBER_LSB    = TARGET_LSB + DISK_W;
    localparam int BYTE_LSB      = MEMBER_LSB + DISK_W;
    localparam int IN_TDATA_W    = BYTE_LSB + BYTE_W;
    localparam int OUT_TDATA_W   = BYTE_W;
    localparam int OUT_TUSER_W   = 4;

    // Remainder unit: stripe bits consumed per cycle.
    localparam int MOD_BITS_PER_STEP = 4;
    localparam int MOD_STEPS         = STRIPE_W / MOD_BITS_PER_STEP;
    localparam int MOD_CNT_W         = $clog2(MOD_STEPS);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DISK_COUNT  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_MASK = 1'b1;

    localparam logic [DISK_COUNT_W-1:0] DISK_COUNT_MIN   = 5'd4;
    localparam logic [DISK_COUNT_W-1:0] DISK_COUNT_MAX   = 5'(MAX_DISKS);
    localparam logic [DISK_COUNT_W-1:0] DISK_COUNT_RESET = 5'd4;
    localparam logic [MASK_W-1:0]       ACTIVE_MASK_RESET = 16'hffff;

    // GF(2^8) with polynomial 0x11d and generator 2.
    localparam logic [8:0] GF_POLY = 9'h11d;
    localparam logic [7:0] GF_GEN  = 8'h02;

    typedef enum logic [1:0] {
        PATH_DIRECT,
        PATH_VIA_P,
        PATH_VIA_Q,
        PATH_VIA_PQ
    } path_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_TARGET_PARITY_LOST,
        ST_TWO_PARITY_LOST,
        ST_OVER_TWO
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_ACC,
        S_SCAN,
        S_MUL1,
        S_MUL2,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mod_step;
        logic accumulate;
        logic scan;
        logic mul1;
        logic mul2;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_item;
    } ctrl_status_t;

    typedef logic [7:0] gf_table_t [256];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                r = r ^ x[7:0];
            end
            x = x << 1;
            if (x[8])
            begin
                x = x ^ GF_POLY;
            end
        end
        return r;
    endfunction

    // Powers of the generator; entry 255 wraps back to one.
    function automatic gf_table_t gf_build_exp();
        gf_table_t t;
        logic [7:0] e;
        e = 8'd1;
        for (int k = 0; k < 256; k++)
        begin
            t[k] = e;
            e = gf_mul(e, GF_GEN);
        end
        return t;
    endfunction

    // Multiplicative inverses; zero maps to zero.
    function automatic gf_table_t gf_build_inv();
        gf_table_t t;
        gf_table_t ex;
        ex = gf_build_exp();
        t[0] = 8'd0;
        for (int k = 0; k < 255; k++)
        begin
            t[ex[k]] = ex[(k == 0) ? 0 : 255 - k];
        end
        return t;
    endfunction

    localparam gf_table_t GF_EXP = gf_build_exp();
    localparam gf_table_t GF_INV = gf_build_inv();

endpackage

@@ hw/rtl/raid6_pq_byte_recovery_core.sv @@
// RAID-6 single-byte recovery: member bytes of one stripe column are streamed
// in, one item per member, in any order, and on the item flagged with tlast the
// block returns the wanted data byte together with the path used to get it
// (read directly, rebuilt through P, through Q, or through P and Q together
// when two data disks are lost) and a status that is nonzero when the byte
// cannot be recovered. P and Q rotate with the stripe number over the
// configured disk count, and the arithmetic is GF(2^8) with polynomial 0x11d
// and generator 2. Each item, before the next is taken, passes through the
// accept state, the remainder unit that reduces the 32-bit stripe number
// modulo the disk count four bits per cycle, and an accumulate state. The
// last item of a column then goes through the scan, first multiply, second
// multiply and emit states, waiting in emit while the previous result is
// still waiting on the output. Inactive members and member indexes at or
// above the disk count are accepted and not accumulated. The user must write
// configuration only while the block is idle; the block does not enforce it.
module raid6_pq_byte_recovery_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // Configuration write port: index 0 disk_count, index 1 active_mask.
    input  logic                                 cfg_wr_en,
    input  logic [r6r_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [r6r_pkg::CFG_DATA_W-1:0]       cfg_data,

    // Member byte items.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0 up: stripe[31:0], target_slot[35:32],
    // member[39:36], data_byte[47:40].
    input  logic [r6r_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // last_member.
    input  logic                                 s_axis_tlast,

    // Recovered byte items.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // Fields from bit 0 up: recovered_byte[7:0].
    output logic [r6r_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Fields from bit 0 up: recovery_path[1:0], status[3:2].
    output logic [r6r_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

    r6r_pkg::ctrl_cmd_t     cmd;
    r6r_pkg::ctrl_status_t  dp_status;
    r6r_pkg::path_t         out_path;
    r6r_pkg::status_t       out_status;

    // The controller sequences one item at a time and owns the output valid.
    r6r_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .status    (dp_status),
        .cmd       (cmd)
    );

    // The datapath holds configuration, the P and Q accumulators, the
    // remainder unit, the GF multipliers and the output register.
    r6r_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_tdata   (s_axis_tdata),
        .in_tlast   (s_axis_tlast),
        .cmd        (cmd),
        .status     (dp_status),
        .out_byte   (m_axis_tdata),
        .out_path   (out_path),
        .out_status (out_status)
    );

    assign m_axis_tuser = {out_status, out_path};

endmodule

@@ hw/rtl/r6r_ctrl.sv @@
module r6r_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   out_ready,
    output logic                   out_valid,
    input  r6r_pkg::ctrl_status_t  status,
    output r6r_pkg::ctrl_cmd_t     cmd
);

    r6r_pkg::state_t                 state_reg;
    r6r_pkg::state_t                 state_next;
    logic [r6r_pkg::MOD_CNT_W-1:0]   mod_cnt_reg;
    logic [r6r_pkg::MOD_CNT_W-1:0]   mod_cnt_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;

    localparam logic [r6r_pkg::MOD_CNT_W-1:0] MOD_CNT_LAST =
        r6r_pkg::MOD_CNT_W'(r6r_pkg::MOD_STEPS - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= r6r_pkg::S_IDLE;
            mod_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_cnt_reg   <= mod_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mod_cnt_next   = mod_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            r6r_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    mod_cnt_next = '0;
                    state_next   = r6r_pkg::S_MOD;
                end
            end
            r6r_pkg::S_MOD:
            begin
                cmd.mod_step = 1'b1;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_cnt_reg == MOD_CNT_LAST)
                begin
                    mod_cnt_next = '0;
                    state_next   = r6r_pkg::S_ACC;
                end
            end
            r6r_pkg::S_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next = status.last_item ? r6r_pkg::S_SCAN : r6r_pkg::S_IDLE;
            end
            r6r_pkg::S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = r6r_pkg::S_MUL1;
            end
            r6r_pkg::S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = r6r_pkg::S_MUL2;
            end
            r6r_pkg::S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = r6r_pkg::S_EMIT;
            end
            r6r_pkg::S_EMIT:
            begin
                // Wait here while the previous result is still held.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = r6r_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = r6r_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/r6r_datapath.sv @@
module r6r_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [r6r_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [r6r_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [r6r_pkg::IN_TDATA_W-1:0]      in_tdata,
    input  logic                                in_tlast,
    input  r6r_pkg::ctrl_cmd_t                  cmd,
    output r6r_pkg::ctrl_status_t               status,
    output logic [r6r_pkg::BYTE_W-1:0]          out_byte,
    output r6r_pkg::path_t                      out_path,
    output r6r_pkg::status_t                    out_status
);

    localparam int DW = r6r_pkg::DISK_W;
    localparam int CW = r6r_pkg::DISK_COUNT_W;
    localparam int BW = r6r_pkg::BYTE_W;

    // Configuration.
    logic [CW-1:0]               disk_count_reg;
    logic [r6r_pkg::MASK_W-1:0]  active_mask_reg;

    // Current item and remainder unit.
    logic [r6r_pkg::STRIPE_W-1:0] shift_reg;
    logic [DW-1:0]                rem_reg;
    logic [DW-1:0]                rem_next;
    logic [DW-1:0]                trem_reg;
    logic [DW-1:0]                trem_next;
    logic [DW-1:0]                member_reg;
    logic [BW-1:0]                byte_reg;
    logic                         last_reg;

    // Column state.
    logic [BW-1:0]                p_acc_reg;
    logic [BW-1:0]                q_acc_reg;
    logic [BW-1:0]                direct_reg;

    // Decision and solve registers.
    r6r_pkg::path_t               path_reg;
    r6r_pkg::path_t               path_next;
    r6r_pkg::status_t             stat_reg;
    r6r_pkg::status_t             stat_next;
    logic [BW-1:0]                gi_reg;
    logic [BW-1:0]                gj_reg;
    logic [BW-1:0]                ginv_t_reg;
    logic                         tgt_f0_reg;
    logic [BW-1:0]                prod_reg;
    logic [BW-1:0]                inv_reg;
    logic [BW-1:0]                xi_reg;
    logic [BW-1:0]                out_byte_reg;
    r6r_pkg::path_t               out_path_reg;
    r6r_pkg::status_t             out_status_reg;

    // Combinational helpers.
    logic [CW-1:0]                n_disks;
    logic [DW-1:0]                n_minus2;
    logic [DW-1:0]                p_disk;
    logic [DW-1:0]                q_disk;
    logic [DW-1:0]                t_disk;
    logic [DW-1:0]                member_slot;
    logic [DW-1:0]                t_slot;
    logic                         member_active;
    logic [BW-1:0]                q_term;
    logic [DW-1:0]                mod_r;
    logic [CW-1:0]                mod_wide;
    logic [r6r_pkg::MASK_W-1:0]   failed_vec;
    logic [r6r_pkg::MASK_W-1:0]   failed_rest;
    logic [DW-1:0]                failed0;
    logic [DW-1:0]                failed1;
    logic [CW-1:0]                failed_cnt;
    logic [BW-1:0]                mul_a;
    logic [BW-1:0]                mul_b;
    logic [BW-1:0]                result_byte;

    function automatic logic [DW-1:0] slot_of(input logic [DW-1:0] d,
                                              input logic [DW-1:0] p,
                                              input logic [DW-1:0] q);
        logic [DW-1:0] s;
        if (p == '0)
        begin
            s = d - 1'b1;
        end
        else if (d < q)
        begin
            s = d;
        end
        else
        begin
            s = d - 4'd2;
        end
        return s;
    endfunction

    function automatic logic [DW-1:0] first_set(input logic [r6r_pkg::MASK_W-1:0] v);
        logic [DW-1:0] idx;
        idx = '0;
        for (int i = r6r_pkg::MASK_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = DW'(i);
            end
        end
        return idx;
    endfunction

    // Disk count is clamped into the supported range.
    always_comb
    begin
        if (disk_count_reg < r6r_pkg::DISK_COUNT_MIN)
        begin
            n_disks = r6r_pkg::DISK_COUNT_MIN;
        end
        else if (disk_count_reg > r6r_pkg::DISK_COUNT_MAX)
        begin
            n_disks = r6r_pkg::DISK_COUNT_MAX;
        end
        else
        begin
            n_disks = disk_count_reg;
        end
    end

    assign n_minus2 = DW'(n_disks - 5'd2);

    // Four radix-2 remainder steps per cycle on the stripe number.
    always_comb
    begin
        mod_r = rem_reg;
        mod_wide = '0;
        for (int k = 0; k < r6r_pkg::MOD_BITS_PER_STEP; k++)
        begin
            mod_wide = {mod_r, shift_reg[r6r_pkg::STRIPE_W - 1 - k]};
            if (mod_wide >= n_disks)
            begin
                mod_wide = mod_wide - n_disks;
            end
            mod_r = mod_wide[DW-1:0];
        end
        rem_next = mod_r;
    end

    // The target slot is reduced by one conditional subtract per cycle.
    assign trem_next = (trem_reg >= n_minus2) ? (trem_reg - n_minus2) : trem_reg;

    // Parity placement and the target disk, valid once the remainder is done.
    assign p_disk = DW'(n_disks - 5'd1 - {1'b0, rem_reg});
    assign q_disk = (p_disk == '0) ? DW'(n_disks - 5'd1) : (p_disk - 1'b1);

    always_comb
    begin
        if (p_disk == '0)
        begin
            t_disk = trem_reg + 1'b1;
        end
        else if (trem_reg < q_disk)
        begin
            t_disk = trem_reg;
        end
        else
        begin
            t_disk = trem_reg + 4'd2;
        end
    end

    assign member_slot   = slot_of(member_reg, p_disk, q_disk);
    assign t_slot        = slot_of(t_disk, p_disk, q_disk);
    assign member_active = ({1'b0, member_reg} < n_disks) && active_mask_reg[member_reg];
    assign q_term        = r6r_pkg::gf_mul(byte_reg, r6r_pkg::GF_EXP[{4'd0, member_slot}]);

    // Lost data disks of the column.
    always_comb
    begin
        for (int i = 0; i < r6r_pkg::MASK_W; i++)
        begin
            failed_vec[i] = (CW'(i) < n_disks) && (DW'(i) != p_disk) &&
                            (DW'(i) != q_disk) && !active_mask_reg[i];
        end
    end

    assign failed_rest = failed_vec & (failed_vec - 1'b1);
    assign failed0     = first_set(failed_vec);
    assign failed1     = first_set(failed_rest);
    assign failed_cnt  = CW'($countones(failed_vec));

    always_comb
    begin
        path_next = r6r_pkg::PATH_DIRECT;
        stat_next = r6r_pkg::ST_OK;
        if (!active_mask_reg[t_disk])
        begin
            case (failed_cnt)
                5'd1:
                begin
                    if (active_mask_reg[p_disk])
                    begin
                        path_next = r6r_pkg::PATH_VIA_P;
                    end
                    else if (active_mask_reg[q_disk])
                    begin
                        path_next = r6r_pkg::PATH_VIA_Q;
                    end
                    else
                    begin
                        stat_next = r6r_pkg::ST_TARGET_PARITY_LOST;
                    end
                end
                5'd2:
                begin
                    if (!active_mask_reg[p_disk] || !active_mask_reg[q_disk])
                    begin
                        stat_next = r6r_pkg::ST_TWO_PARITY_LOST;
                    end
                    else
                    begin
                        path_next = r6r_pkg::PATH_VIA_PQ;
                    end
                end
                default:
                begin
                    stat_next = r6r_pkg::ST_OVER_TWO;
                end
            endcase
        end
    end

    assign mul_a = (path_reg == r6r_pkg::PATH_VIA_Q) ? q_acc_reg : gj_reg;
    assign mul_b = (path_reg == r6r_pkg::PATH_VIA_Q) ? ginv_t_reg : p_acc_reg;

    always_comb
    begin
        result_byte = '0;
        if (stat_reg == r6r_pkg::ST_OK)
        begin
            case (path_reg)
                r6r_pkg::PATH_DIRECT: result_byte = direct_reg;
                r6r_pkg::PATH_VIA_P:  result_byte = p_acc_reg;
                r6r_pkg::PATH_VIA_Q:  result_byte = prod_reg;
                r6r_pkg::PATH_VIA_PQ: result_byte = tgt_f0_reg ? xi_reg : (p_acc_reg ^ xi_reg);
                default:              result_byte = '0;
            endcase
        end
    end

    // Control-side registers: configuration and column state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_count_reg  <= r6r_pkg::DISK_COUNT_RESET;
            active_mask_reg <= r6r_pkg::ACTIVE_MASK_RESET;
            p_acc_reg       <= '0;
            q_acc_reg       <= '0;
            direct_reg      <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    r6r_pkg::CFG_DISK_COUNT:  disk_count_reg  <= cfg_data[CW-1:0];
                    r6r_pkg::CFG_ACTIVE_MASK: active_mask_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                last_reg <= in_tlast;
            end
            if (cmd.accumulate && member_active)
            begin
                if (member_reg == p_disk)
                begin
                    p_acc_reg <= p_acc_reg ^ byte_reg;
                end
                else if (member_reg == q_disk)
                begin
                    q_acc_reg <= q_acc_reg ^ byte_reg;
                end
                else
                begin
                    p_acc_reg <= p_acc_reg ^ byte_reg;
                    q_acc_reg <= q_acc_reg ^ q_term;
                    if (member_reg == t_disk)
                    begin
                        direct_reg <= byte_reg;
                    end
                end
            end
            if (cmd.emit)
            begin
                p_acc_reg <= '0;
                q_acc_reg <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            shift_reg  <= in_tdata[r6r_pkg::STRIPE_LSB +: r6r_pkg::STRIPE_W];
            rem_reg    <= '0;
            trem_reg   <= in_tdata[r6r_pkg::TARGET_LSB +: DW];
            member_reg <= in_tdata[r6r_pkg::MEMBER_LSB +: DW];
            byte_reg   <= in_tdata[r6r_pkg::BYTE_LSB +: BW];
        end
        if (cmd.mod_step)
        begin
            shift_reg <= {shift_reg[r6r_pkg::STRIPE_W - r6r_pkg::MOD_BITS_PER_STEP - 1:0],
                          {r6r_pkg::MOD_BITS_PER_STEP{1'b0}}};
            rem_reg   <= rem_next;
            trem_reg  <= trem_next;
        end
        if (cmd.scan)
        begin
            path_reg   <= path_next;
            stat_reg   <= stat_next;
            gi_reg     <= r6r_pkg::GF_EXP[{4'd0, slot_of(failed0, p_disk, q_disk)}];
            gj_reg     <= r6r_pkg::GF_EXP[{4'd0, slot_of(failed1, p_disk, q_disk)}];
            ginv_t_reg <= r6r_pkg::GF_EXP[8'd255 - {4'd0, t_slot}];
            tgt_f0_reg <= (failed0 == t_disk);
        end
        if (cmd.mul1)
        begin
            prod_reg <= r6r_pkg::gf_mul(mul_a, mul_b);
            inv_reg  <= r6r_pkg::GF_INV[gi_reg ^ gj_reg];
        end
        if (cmd.mul2)
        begin
            xi_reg <= r6r_pkg::gf_mul(prod_reg ^ q_acc_reg, inv_reg);
        end
        if (cmd.emit)
        begin
            out_byte_reg   <= result_byte;
            out_path_reg   <= path_reg;
            out_status_reg <= stat_reg;
        end
    end

    assign status.last_item = last_reg;
    assign out_byte         = out_byte_reg;
    assign out_path         = out_path_reg;
    assign out_status       = out_status_reg;

endmodule

@@ hw/rtl/r6r_checker.sv @@
`include "assert_macros.svh"

module r6r_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [r6r_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input logic [r6r_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    // A result that is not taken stays on the port unchanged.
    `R6R_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // An error status always comes with a zero byte and the direct path code.
    `R6R_ASSERT_IMPLY(a_error_zero, clk, rst_n, m_axis_tvalid && (m_axis_tuser[3:2] != r6r_pkg::ST_OK), (m_axis_tdata == 8'd0) && (m_axis_tuser[1:0] == r6r_pkg::PATH_DIRECT))

    // An accepted item keeps the input closed while the remainder unit runs.
    `R6R_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // No result can appear in the cycle right after an item is taken.
    `R6R_ASSERT_NEXT(a_no_early_result, clk, rst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

endmodule

bind raid6_pq_byte_recovery_core r6r_checker u_r6r_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ dv/raid6_pq_byte_recovery_core_tb.sv @@
`timescale 1ns / 1ps

module raid6_pq_byte_recovery_core_tb;

    import r6r_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    // An item with no result keeps the block busy until it is accumulated, so this
    // margin covers it before any register write or the final verdict.
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 110;
    localparam int PRESSURE_PHASE = 8;
    // Low byte of the field polynomial 0x11d, used when a doubling overflows.
    localparam logic [7:0] GF_REDUCE = 8'h1d;

    // One recovered byte as it should leave the block.
    typedef struct packed {
        logic [7:0] value;
        path_t      path;
        status_t    status;
    } rebuilt_t;

    typedef enum logic { ROW_WRITE, ROW_MEMBER } row_kind_t;

    // One row of the directed stimulus: either a register write or a member
    // item, the latter optionally carrying its hand-computed result.
    typedef struct {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [31:0]            stripe;
        logic [3:0]             target;
        logic [3:0]             member;
        logic [7:0]             data;
        logic                   last;
        logic                   known;
        rebuilt_t               golden;
    } plan_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // Fields from bit 0 up: stripe, target_slot, member, data_byte.
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // last_member.
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0 up: recovered_byte.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // Fields from bit 0 up: recovery_path, status.
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // Predictor copy of the configuration and of the column accumulators.
    logic [4:0]  cfg_disks;
    logic [15:0] cfg_mask;
    logic [7:0]  acc_p;
    logic [7:0]  acc_q;
    logic [7:0]  held_byte;

    // Recovered bytes predicted but not yet seen on the output.
    rebuilt_t    pending_rebuilds[$];

    int unsigned fault_count = 0;
    int unsigned raw_items;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    logic        hold_request = 1'b0;
    int unsigned hold_left = 0;

    raid6_pq_byte_recovery_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // ------------------------------------------------------------------
    // GF(2^8) arithmetic for the predictor.
    // ------------------------------------------------------------------

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
    endfunction

    // Horner form: walk the multiplier from its top bit down.
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 7; i >= 0; i--)
        begin
            r = gf_double(r) ^ (b[i] ? a : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] gf_two_pow(input int unsigned k);
        logic [7:0] r;
        r = 8'h01;
        repeat (k)
        begin
            r = gf_double(r);
        end
        return r;
    endfunction

    // Every nonzero element satisfies b^255 = 1, so b^254 is its inverse.
    function automatic logic [7:0] gf_reciprocal(input logic [7:0] b);
        logic [7:0] r;
        r = 8'h01;
        repeat (254)
        begin
            r = gf_times(r, b);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Array geometry.
    // ------------------------------------------------------------------

    function automatic int unsigned clamp_disks(input int unsigned raw);
        if (raw < 4)
        begin
            return 4;
        end
        if (raw > MAX_DISKS)
        begin
            return MAX_DISKS;
        end
        return raw;
    endfunction

    function automatic logic disk_usable(input int unsigned d);
        return d < 16 && cfg_mask[d];
    endfunction

    // Data slot number of a disk that holds neither parity.
    function automatic int unsigned slot_index(input int unsigned d, input int unsigned pd,
                                               input int unsigned qd);
        int unsigned s;
        s = 0;
        for (int unsigned i = 0; i < d; i++)
        begin
            if (i != pd && i != qd)
            begin
                s++;
            end
        end
        return s;
    endfunction

    // Disk that carries a given data slot.
    function automatic int unsigned slot_disk(input int unsigned t, input int unsigned n,
                                              input int unsigned pd, input int unsigned qd);
        int unsigned s;
        s = 0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (i != pd && i != qd)
            begin
                if (s == t)
                begin
                    return i;
                end
                s++;
            end
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Predictor: folds one accepted member item into the column state and,
    // on the last member of a column, works out the recovered byte.
    // ------------------------------------------------------------------
    task automatic predict_member(input logic [31:0] stripe, input logic [3:0] target,
                                  input logic [3:0] member, input logic [7:0] data,
                                  input logic last, output logic produced,
                                  output rebuilt_t outcome);
        int unsigned n;
        int unsigned pd;
        int unsigned qd;
        int unsigned tdisk;
        int unsigned lost_cnt;
        int unsigned lost_disk[2];
        logic [7:0]  gi;
        logic [7:0]  gj;
        logic [7:0]  num;
        logic [7:0]  xi;
        n = clamp_disks(cfg_disks);
        pd = (n - 1) - (stripe % n);
        qd = (pd == 0) ? n - 1 : pd - 1;
        tdisk = slot_disk(target % (n - 2), n, pd, qd);
        produced = 1'b0;
        outcome = '{value: 8'h00, path: PATH_DIRECT, status: ST_OK};

        // Ignored members: out of range or marked unusable.
        if (member < n && disk_usable(member))
        begin
            if (member == pd)
            begin
                acc_p ^= data;
            end
            else if (member == qd)
            begin
                acc_q ^= data;
            end
            else
            begin
                acc_p ^= data;
                acc_q ^= gf_times(data, gf_two_pow(slot_index(member, pd, qd)));
                if (member == tdisk)
                begin
                    held_byte = data;
                end
            end
        end

        if (last)
        begin
            produced = 1'b1;
            if (disk_usable(tdisk))
            begin
                // The held byte survives columns where the target never showed up.
                outcome.value = held_byte;
            end
            else
            begin
                lost_cnt = 0;
                lost_disk[0] = 0;
                lost_disk[1] = 0;
                for (int unsigned d = 0; d < n; d++)
                begin
                    if (d != pd && d != qd && !disk_usable(d))
                    begin
                        if (lost_cnt < 2)
                        begin
                            lost_disk[lost_cnt] = d;
                        end
                        lost_cnt++;
                    end
                end
                if (lost_cnt == 1)
                begin
                    if (disk_usable(pd))
                    begin
                        outcome.value = acc_p;
                        outcome.path = PATH_VIA_P;
                    end
                    else if (disk_usable(qd))
                    begin
                        outcome.value = gf_times(acc_q,
                            gf_reciprocal(gf_two_pow(slot_index(tdisk, pd, qd))));
                        outcome.path = PATH_VIA_Q;
                    end
                    else
                    begin
                        outcome.status = ST_TARGET_PARITY_LOST;
                    end
                end
                else if (lost_cnt == 2)
                begin
                    if (!disk_usable(pd) || !disk_usable(qd))
                    begin
                        outcome.status = ST_TWO_PARITY_LOST;
                    end
                    else
                    begin
                        // Two unknowns: solve with both syndromes.
                        gi = gf_two_pow(slot_index(lost_disk[0], pd, qd));
                        gj = gf_two_pow(slot_index(lost_disk[1], pd, qd));
                        num = gf_times(gj, acc_p) ^ acc_q;
                        xi = gf_times(num, gf_reciprocal(gi ^ gj));
                        outcome.value = (lost_disk[0] == tdisk) ? xi : acc_p ^ xi;
                        outcome.path = PATH_VIA_PQ;
                    end
                end
                else
                begin
                    outcome.status = ST_OVER_TWO;
                end
            end
            acc_p = 8'h00;
            acc_q = 8'h00;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side. Every task here is entered and left just after a falling
    // edge, so all input changes land on falling edges.
    // ------------------------------------------------------------------

    // Offers one member item, waits for the handshake and records what the
    // block should answer. A known result from the directed table replaces the
    // predicted one, while the predictor state still advances.
    task automatic send_member(input logic [31:0] stripe, input logic [3:0] target,
                               input logic [3:0] member, input logic [7:0] data,
                               input logic last, input logic known, input rebuilt_t golden);
        logic     produced;
        rebuilt_t outcome;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {data, member, target, stripe};
        s_axis_tlast <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_member(stripe, target, member, data, last, produced, outcome);
        if (produced)
        begin
            pending_rebuilds = {pending_rebuilds, (known ? golden : outcome)};
        end
        raw_items++;
        @(negedge clk);
    endtask

    // Waits until every recovered byte has come out, then lets a trailing
    // item with no result finish its pass through the block.
    task automatic settle();
        while (pending_rebuilds.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_DISK_COUNT)
        begin
            cfg_disks = value[4:0];
        end
        else
        begin
            cfg_mask = value;
        end
    endtask

    // A well-formed stripe column: real data with matching P and Q, every
    // member sent once in shuffled order. Some columns are damaged on
    // purpose: a member dropped, a stray member added, or one item carrying a
    // different stripe number.
    task automatic run_column();
        int unsigned n;
        int unsigned pd;
        int unsigned qd;
        logic [31:0] stripe;
        logic [3:0]  target;
        logic [7:0]  disk_byte[16];
        logic [7:0]  par_p;
        logic [7:0]  par_q;
        int          order[$];
        int          k;
        int          pick;
        int          tmp;
        int          bent;
        n = clamp_disks(cfg_disks);
        case ($urandom_range(7))
            0: stripe = $urandom_range(40);
            1: stripe = 32'hffff_ffff - $urandom_range(3);
            default: stripe = $urandom();
        endcase
        pd = (n - 1) - (stripe % n);
        qd = (pd == 0) ? n - 1 : pd - 1;
        target = ($urandom_range(6) == 0) ? 4'($urandom()) : 4'($urandom_range(n - 3));
        par_p = 8'h00;
        par_q = 8'h00;
        for (k = 0; k < 16; k++)
        begin
            disk_byte[k] = 8'($urandom());
            if (k < n && k != pd && k != qd)
            begin
                par_p ^= disk_byte[k];
                par_q ^= gf_times(disk_byte[k], gf_two_pow(slot_index(k, pd, qd)));
            end
        end
        disk_byte[pd] = par_p;
        disk_byte[qd] = par_q;
        for (k = 0; k < n; k++)
        begin
            order = {order, k};
        end
        for (k = n - 1; k > 0; k--)
        begin
            pick = $urandom_range(k);
            tmp = order[k];
            order[k] = order[pick];
            order[pick] = tmp;
        end
        if ($urandom_range(9) == 0)
        begin
            order.delete($urandom_range(order.size() - 1));
        end
        if ($urandom_range(9) == 0)
        begin
            order.insert($urandom_range(order.size()), $urandom_range(15));
        end
        bent = ($urandom_range(9) == 0) ? $urandom_range(order.size() - 1) : -1;
        for (k = 0; k < order.size(); k++)
        begin
            send_member((k == bent) ? $urandom() : stripe, target, 4'(order[k]),
                        disk_byte[order[k]], k == order.size() - 1, 1'b0, '0);
        end
    endtask

    // A short burst of items with every field random.
    task automatic run_noise();
        int unsigned count;
        int unsigned k;
        count = $urandom_range(1, 6);
        for (k = 0; k < count; k++)
        begin
            send_member($urandom(), 4'($urandom()), 4'($urandom()), 8'($urandom()),
                        (k == count - 1) || ($urandom_range(3) == 0), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Directed table rows.
    // ------------------------------------------------------------------

    function automatic plan_row_t reg_row(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] value);
        plan_row_t r;
        r = '{kind: ROW_WRITE, reg_index: index, reg_value: value, stripe: '0, target: '0,
              member: '0, data: '0, last: 1'b0, known: 1'b0, golden: '0};
        return r;
    endfunction

    function automatic plan_row_t mem_row(input logic [31:0] stripe, input logic [3:0] target,
                                          input logic [3:0] member, input logic [7:0] data,
                                          input logic last);
        plan_row_t r;
        r = '{kind: ROW_MEMBER, reg_index: '0, reg_value: '0, stripe: stripe, target: target,
              member: member, data: data, last: last, known: 1'b0, golden: '0};
        return r;
    endfunction

    function automatic plan_row_t chk_row(input logic [31:0] stripe, input logic [3:0] target,
                                          input logic [3:0] member, input logic [7:0] data,
                                          input logic [7:0] value, input path_t path,
                                          input status_t status);
        plan_row_t r;
        r = mem_row(stripe, target, member, data, 1'b1);
        r.known = 1'b1;
        r.golden = '{value: value, path: path, status: status};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Output side: the receiver stalls at random and, on request, holds off
    // for a long stretch so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Each accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin
        rebuilt_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_rebuilds.size() == 0)
            begin
                $error("unexpected result: recovered_byte %h, tuser %h",
                       m_axis_tdata, m_axis_tuser);
                fault_count++;
            end
            else
            begin
                want = pending_rebuilds.pop_front();
                if (m_axis_tdata != want.value)
                begin
                    $error("recovered_byte: expected %h, got %h", want.value, m_axis_tdata);
                    fault_count++;
                end
                if (path_t'(m_axis_tuser[1:0]) != want.path)
                begin
                    $error("recovery_path: expected %0d, got %0d", want.path,
                           m_axis_tuser[1:0]);
                    fault_count++;
                end
                if (status_t'(m_axis_tuser[3:2]) != want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser[3:2]);
                    fault_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        plan_row_t   plan[$];
        int          phase;
        int unsigned disk_plan[PHASES];
        int unsigned loss_plan[PHASES];
        int unsigned disks;
        int unsigned lost;
        int unsigned n_eff;
        int unsigned bit_no;
        logic [15:0] mask;

        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        src_idle_pct = 11;
        sink_idle_pct = 87;
        cfg_disks = DISK_COUNT_RESET;
        cfg_mask = ACTIVE_MASK_RESET;
        acc_p = 8'h00;
        acc_q = 8'h00;
        held_byte = 8'h00;
        repeat (RESET_CYCLES)
        begin
            @(negedge clk);
        end
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Four disks out of reset; stripe 0 puts P on disk 3
        // and Q on disk 2, the all-ones stripe puts P on disk 0 and Q on 3.
        // A last flag on an out-of-range member still closes the column, and
        // the target byte is still the reset value.
        plan = {plan, chk_row(32'h0, 4'd0, 4'd15, 8'hff, 8'h00, PATH_DIRECT, ST_OK)};
        plan = {plan, chk_row(32'h0, 4'd0, 4'd0, 8'ha5, 8'ha5, PATH_DIRECT, ST_OK)};
        // Largest stripe and slot: slot 15 wraps to slot 1, which is disk 2.
        plan = {plan, mem_row(32'hffff_ffff, 4'd15, 4'd2, 8'hff, 1'b0)};
        plan = {plan, chk_row(32'hffff_ffff, 4'd15, 4'd0, 8'h00, 8'hff, PATH_DIRECT, ST_OK)};
        // Target disk usable but its byte missing from the column.
        plan = {plan, chk_row(32'h0, 4'd1, 4'd3, 8'h3c, 8'hff, PATH_DIRECT, ST_OK)};
        // Disk 0 lost: rebuilt through P from data 0x12/0x34, P 0x26, Q 0x7a.
        plan = {plan, reg_row(CFG_ACTIVE_MASK, 16'hfffe)};
        plan = {plan, mem_row(32'h0, 4'd0, 4'd1, 8'h34, 1'b0)};
        plan = {plan, mem_row(32'h0, 4'd0, 4'd3, 8'h26, 1'b0)};
        plan = {plan, mem_row(32'h0, 4'd0, 4'd0, 8'h12, 1'b0)};
        plan = {plan, chk_row(32'h0, 4'd0, 4'd2, 8'h7a, 8'h12, PATH_VIA_P, ST_OK)};
        // Disk 0 and P lost: through Q.
        plan = {plan, reg_row(CFG_ACTIVE_MASK, 16'hfff6)};
        plan = {plan, mem_row(32'h0, 4'd0, 4'd1, 8'h34, 1'b0)};
        plan = {plan, mem_row(32'h0, 4'd0, 4'd2, 8'h7a, 1'b1)};
        // Both data disks lost: through P and Q.
        plan = {plan, reg_row(CFG_ACTIVE_MASK, 16'hfffc)};
        plan = {plan, mem_row(32'h0, 4'd1, 4'd3, 8'h26, 1'b0)};
        plan = {plan, mem_row(32'h0, 4'd1, 4'd2, 8'h7a, 1'b1)};
        // Target and both parities lost.
        plan = {plan, reg_row(CFG_ACTIVE_MASK, 16'hfff2)};
        plan = {plan, chk_row(32'h0, 4'd0, 4'd1, 8'h34, 8'h00, PATH_DIRECT,
                              ST_TARGET_PARITY_LOST)};
        // Two data disks and P lost.
        plan = {plan, reg_row(CFG_ACTIVE_MASK, 16'hfff4)};
        plan = {plan, chk_row(32'h0, 4'd0, 4'd2, 8'h7a, 8'h00, PATH_DIRECT,
                              ST_TWO_PARITY_LOST)};
        // Five disks, three data disks lost.
        plan = {plan, reg_row(CFG_DISK_COUNT, 16'd5)};
        plan = {plan, reg_row(CFG_ACTIVE_MASK, 16'hfff8)};
        plan = {plan, chk_row(32'h0, 4'd2, 4'd0, 8'h55, 8'h00, PATH_DIRECT, ST_OVER_TWO)};
        // Disk count above the maximum clamps to sixteen; nothing usable.
        plan = {plan, reg_row(CFG_DISK_COUNT, 16'd31)};
        plan = {plan, reg_row(CFG_ACTIVE_MASK, 16'h0000)};
        plan = {plan, chk_row(32'h7, 4'd0, 4'd9, 8'h00, 8'h00, PATH_DIRECT, ST_OVER_TWO)};
        // Disk count of zero clamps to four.
        plan = {plan, reg_row(CFG_DISK_COUNT, 16'd0)};
        plan = {plan, reg_row(CFG_ACTIVE_MASK, 16'hffff)};
        plan = {plan, mem_row(32'h2, 4'd3, 4'd5, 8'h99, 1'b1)};

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_WRITE)
            begin
                write_register(plan[r].reg_index, plan[r].reg_value);
            end
            else
            begin
                send_member(plan[r].stripe, plan[r].target, plan[r].member, plan[r].data,
                            plan[r].last, plan[r].known, plan[r].golden);
            end
        end

        // Random part. Each phase sets a disk count and a loss pattern; the
        // rotation of P and Q over the stripes then moves the lost disks
        // between data and parity roles, which reaches every recovery path.
        disk_plan = '{4, 16, 5, 31, 3, 8, 17, 12, 0, 16, 0, 6};
        loss_plan = '{0, 1, 2, 2, 1, 3, 2, 0, 2, 16, 0, 2};
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 4)
                0:
                begin
                    src_idle_pct = 11;
                    sink_idle_pct = 87;
                end
                1:
                begin
                    src_idle_pct = 87;
                    sink_idle_pct = 11;
                end
                default:
                begin
                    src_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            disks = disk_plan[phase];
            lost = loss_plan[phase];
            if (phase == 10)
            begin
                disks = $urandom_range(4, 16);
                lost = $urandom_range(3);
            end
            n_eff = clamp_disks(disks);
            // Bits above the disk count are random; the block ignores them.
            mask = 16'($urandom());
            for (bit_no = 0; bit_no < n_eff; bit_no++)
            begin
                mask[bit_no] = 1'b1;
            end
            if (lost >= 16)
            begin
                mask = 16'h0000;
            end
            else
            begin
                repeat (lost)
                begin
                    do
                    begin
                        bit_no = $urandom_range(n_eff - 1);
                    end
                    while (!mask[bit_no]);
                    mask[bit_no] = 1'b0;
                end
            end
            write_register(CFG_DISK_COUNT, 16'(disks));
            write_register(CFG_ACTIVE_MASK, mask);

            // Long receiver stall with the sender running flat out.
            if (phase == PRESSURE_PHASE)
            begin
                @(posedge clk);
                hold_request = 1'b1;
                @(negedge clk);
            end

            raw_items = 0;
            while (raw_items < PHASE_ITEMS)
            begin
                if ($urandom_range(4) == 0)
                begin
                    run_noise();
                end
                else
                begin
                    run_column();
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        settle();
        if (fault_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/r6r_pkg.sv
hw/rtl/r6r_ctrl.sv
hw/rtl/r6r_datapath.sv
hw/rtl/raid6_pq_byte_recovery_core.sv
hw/rtl/r6r_checker.sv
dv/raid6_pq_byte_recovery_core_tb.sv
